@@ hw/rtl/ibfd_pkg.sv @@
// shared types, constants and helper functions for the ibus frame decoder
package ibfd_pkg;

	localparam int FRAME_LEN = 32;
	localparam int SUM_BYTES = 30;
	localparam int NUM_STICKS = 4;
	localparam int NUM_SWITCHES = 4;
	localparam int NUM_KNOBS = 2;

	localparam logic [7:0] HDR0 = 8'h20;
	localparam logic [7:0] HDR1 = 8'h40;

	localparam logic [11:0] W_LOW = 12'd1000;
	localparam logic [11:0] W_MID = 12'd1500;
	localparam logic [11:0] W_HIGH = 12'd2000;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ERROR_LIMIT     = 3'd0,
		CFG_DEADBAND_FINE   = 3'd1,
		CFG_DEADBAND_COARSE = 3'd2,
		CFG_SWITCH_UP       = 3'd3,
		CFG_SWITCH_DOWN     = 3'd4,
		CFG_SWITCH_MID      = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [11:0] error_limit;
		logic [7:0]  db_fine;
		logic [7:0]  db_coarse;
		logic [11:0] sw_up;
		logic [11:0] sw_down;
		logic [11:0] sw_mid;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		error_limit: 12'd1800,
		db_fine:     8'd10,
		db_coarse:   8'd50,
		sw_up:       12'd1,
		sw_down:     12'd2,
		sw_mid:      12'd3
	};

	// sticks are 14-bit two's complement, stick 2 only needs 13 of them
	typedef struct packed {
		logic [NUM_STICKS-1:0][13:0]   stick;
		logic [NUM_SWITCHES-1:0][11:0] sw;
		logic [NUM_KNOBS-1:0][11:0]    knob;
	} rec_t;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	// channel k: low byte then low nibble of the following byte
	function automatic logic [11:0] chan_raw(frame_t f, int unsigned k);
		return {f[2*k+3][3:0], f[2*k+2]};
	endfunction

	function automatic logic [13:0] stick_mag(logic [13:0] v);
		return v[13] ? 14'(-$signed(v)) : v;
	endfunction

	// 2*(raw - 1500)
	function automatic logic [13:0] scale_centered(logic [11:0] raw);
		logic signed [13:0] d;
		d = $signed({2'b00, raw}) - 14'sd1500;
		return 14'(d <<< 1);
	endfunction

	// raw - 1000
	function automatic logic [13:0] scale_offset(logic [11:0] raw);
		logic signed [13:0] d;
		d = $signed({2'b00, raw}) - 14'sd1000;
		return 14'(d);
	endfunction

	function automatic logic [13:0] apply_db(logic [13:0] v, logic [7:0] db);
		return (stick_mag(v) < {6'd0, db}) ? 14'd0 : v;
	endfunction

	function automatic logic [11:0] map_switch(logic [11:0] w, logic three_way, cfg_t c);
		logic [11:0] r;
		r = w;
		if (w == W_LOW) begin
			r = c.sw_up;
		end else if (w == W_HIGH) begin
			r = c.sw_down;
		end else if (three_way && (w == W_MID)) begin
			r = c.sw_mid;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/ibus_frame_decoder_unit.sv @@
// top level of the ibus frame decoder: byte chain, decode stage, check and output register
//
// input channel (in_valid/in_ready): one beat per received byte (action 0) or per
// line-idle event (action 1). bytes shift into a chain of 32 byte cells while the
// frame is shorter than 32 bytes; the byte count saturates at BUF_LEN.
// an idle beat checks length, header and inverted byte sum, snapshots the unpacked
// and scaled channels into the decode stage, and restarts the byte count.
// output channel (out_valid/out_ready): one result beat per idle beat, none per
// byte. the idle beat is registered in the decode stage, then range-checked into
// the output register. throughput is one beat per cycle on the input
// while in_ready is high; bytes and idle events may follow
// each other back to back. the held record updates when a result enters the
// output register, so consecutive idle events see each other's record.
// when the receiver stalls, the decode stage and output register fill and then
// in_ready drops; nothing is lost.
// config port (cfg_we/cfg_index/cfg_data) writes one register per cycle; use it
// only while no result is outstanding. writes beyond the register list are ignored.
// reset clears the byte count, sum, held record, valid flags and restores the
// register defaults; the byte chain contents stay unknown until written.
module ibus_frame_decoder_unit
	import ibfd_pkg::*;
#(
	parameter int BUF_LEN = 36
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [7:0]            rx_byte,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [13:0]           stick_0,
	output logic [13:0]           stick_1,
	output logic [12:0]           stick_2,
	output logic [13:0]           stick_3,
	output logic [11:0]           switch_0,
	output logic [11:0]           switch_1,
	output logic [11:0]           switch_2,
	output logic [11:0]           switch_3,
	output logic [11:0]           knob_0,
	output logic [11:0]           knob_1,
	output logic                  frame_accepted,
	output logic                  data_error
);

	localparam int CNT_W = $clog2(BUF_LEN + 1);

	// configuration registers
	cfg_t cfg_q;

	// byte collection state
	logic [CNT_W-1:0] count_q;
	logic [15:0]      sum_q;
	frame_t           frame;

	// pipeline control
	logic valid_s1;
	logic out_valid_q;
	logic in_fire;
	logic idle_fire;
	logic byte_fire;
	logic s1_adv;
	logic s1_move;
	logic shift_en;
	logic accepted;
	logic [15:0] sum_inv;

	// decode stage and check
	rec_t rec_s1;
	logic accepted_s1;
	rec_t held_q;
	rec_t cand;
	rec_t checked;
	logic bad;

	// output register
	rec_t out_rec_q;
	logic out_acc_q;
	logic out_err_q;

	// handshake: the decode stage frees when the output register can take it
	assign s1_adv    = !out_valid_q || out_ready;
	assign s1_move   = valid_s1 && s1_adv;
	assign in_ready  = !valid_s1 || s1_adv;
	assign in_fire   = in_valid && in_ready;
	assign idle_fire = in_fire && action;
	assign byte_fire = in_fire && !action;

	// only the first FRAME_LEN bytes enter the chain
	assign shift_en = byte_fire && (count_q < CNT_W'(FRAME_LEN));

	// frame check at the idle beat
	assign sum_inv  = ~sum_q;
	assign accepted = (count_q == CNT_W'(FRAME_LEN))
		&& (frame[0] == HDR0) && (frame[1] == HDR1)
		&& (frame[SUM_BYTES] == sum_inv[7:0])
		&& (frame[SUM_BYTES+1] == sum_inv[15:8]);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ERROR_LIMIT:     cfg_q.error_limit <= cfg_data;
				CFG_DEADBAND_FINE:   cfg_q.db_fine     <= cfg_data[7:0];
				CFG_DEADBAND_COARSE: cfg_q.db_coarse   <= cfg_data[7:0];
				CFG_SWITCH_UP:       cfg_q.sw_up       <= cfg_data;
				CFG_SWITCH_DOWN:     cfg_q.sw_down     <= cfg_data;
				CFG_SWITCH_MID:      cfg_q.sw_mid      <= cfg_data;
				default:             cfg_q             <= cfg_q;
			endcase
		end
	end

	// byte count saturates at BUF_LEN, sum covers bytes before the checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (idle_fire) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (byte_fire && (count_q < CNT_W'(BUF_LEN))) begin
			count_q <= count_q + CNT_W'(1);
			if (count_q < CNT_W'(SUM_BYTES)) begin
				sum_q <= sum_q + {8'd0, rx_byte};
			end
		end
	end

	// byte chain: new bytes enter at the top cell, first byte ends in cell 0
	for (genvar k = 0; k < FRAME_LEN; k++) begin : g_chain
		logic [7:0] din;
		if (k == FRAME_LEN - 1) begin : g_head
			assign din = rx_byte;
		end else begin : g_link
			assign din = frame[k+1];
		end
		ibfd_byte_cell u_cell (
			.clk   (clk),
			.shift (shift_en),
			.din   (din),
			.dout  (frame[k])
		);
	end

	// decode stage, loaded by the idle beat
	ibfd_chan_decode u_decode (
		.clk         (clk),
		.load        (idle_fire),
		.frame       (frame),
		.accepted    (accepted),
		.cfg         (cfg_q),
		.rec_s1      (rec_s1),
		.accepted_s1 (accepted_s1)
	);

	// a rejected frame re-checks the held record
	assign cand = accepted_s1 ? rec_s1 : held_q;

	ibfd_rec_check u_check (
		.cand        (cand),
		.error_limit (cfg_q.error_limit),
		.sw_down     (cfg_q.sw_down),
		.result      (checked),
		.bad         (bad)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else begin
			if (idle_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
				held_q      <= checked;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_rec_q <= checked;
			out_acc_q <= accepted_s1;
			out_err_q <= bad;
		end
	end

	assign out_valid      = out_valid_q;
	assign stick_0        = out_rec_q.stick[0];
	assign stick_1        = out_rec_q.stick[1];
	assign stick_2        = out_rec_q.stick[2][12:0];
	assign stick_3        = out_rec_q.stick[3];
	assign switch_0       = out_rec_q.sw[0];
	assign switch_1       = out_rec_q.sw[1];
	assign switch_2       = out_rec_q.sw[2];
	assign switch_3       = out_rec_q.sw[3];
	assign knob_0         = out_rec_q.knob[0];
	assign knob_1         = out_rec_q.knob[1];
	assign frame_accepted = out_acc_q;
	assign data_error     = out_err_q;

	// a flagged record carries zero sticks and down-coded switches
	a_err_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> ((out_rec_q.stick == '0)
			&& (out_rec_q.sw[0] == cfg_q.sw_down) && (out_rec_q.sw[3] == cfg_q.sw_down)))
		else $error("flagged record not cleared");

	// byte count never passes the buffer length
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUF_LEN))
		else $error("byte count beyond buffer length");

	// an idle beat always occupies the decode stage and restarts the count
	a_idle_load: assert property (@(posedge clk) disable iff (!arst_n)
		idle_fire |=> (valid_s1 && (count_q == '0) && (sum_q == '0)))
		else $error("idle beat not taken into decode stage");

	// input only stalls when both stages hold a result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled with room in the pipeline");

endmodule

@@ hw/rtl/ibfd_byte_cell.sv @@
// one byte cell of the frame shift chain
module ibfd_byte_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] din,
	output logic [7:0] dout
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

endmodule

@@ hw/rtl/ibfd_chan_decode.sv @@
// frame unpack, stick scaling, deadband and switch coding, registered
module ibfd_chan_decode
	import ibfd_pkg::*;
(
	input  logic   clk,
	input  logic   load,
	input  frame_t frame,
	input  logic   accepted,
	input  cfg_t   cfg,
	output rec_t   rec_s1,
	output logic   accepted_s1
);

	rec_t rec_d;

	always_comb begin
		rec_d.stick[0] = apply_db(scale_centered(chan_raw(frame, 0)), cfg.db_fine);
		rec_d.stick[1] = apply_db(scale_centered(chan_raw(frame, 1)), cfg.db_fine);
		rec_d.stick[2] = apply_db(scale_offset(chan_raw(frame, 2)), cfg.db_coarse);
		rec_d.stick[3] = apply_db(scale_centered(chan_raw(frame, 3)), cfg.db_coarse);
		rec_d.sw[0]    = map_switch(chan_raw(frame, 4), 1'b0, cfg);
		rec_d.sw[1]    = map_switch(chan_raw(frame, 5), 1'b1, cfg);
		rec_d.sw[2]    = map_switch(chan_raw(frame, 6), 1'b1, cfg);
		rec_d.sw[3]    = map_switch(chan_raw(frame, 7), 1'b0, cfg);
		rec_d.knob[0]  = chan_raw(frame, 8);
		rec_d.knob[1]  = chan_raw(frame, 9);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_s1      <= rec_d;
			accepted_s1 <= accepted;
		end
	end

endmodule

@@ hw/rtl/ibfd_top_dummy_placeholder.sv @@
// record check stage: range and zero-switch test on the candidate record
module ibfd_rec_check
	import ibfd_pkg::*;
(
	input  rec_t        cand,
	input  logic [11:0] error_limit,
	input  logic [11:0] sw_down,
	output rec_t        result,
	output logic        bad
);

	logic [NUM_STICKS-1:0] over;

	always_comb begin
		for (int i = 0; i < NUM_STICKS; i++) begin
			over[i] = stick_mag(cand.stick[i]) > {2'b00, error_limit};
		end
		bad = (|over) || (cand.sw[0] == 12'd0) || (cand.sw[1] == 12'd0);
		result = cand;
		if (bad) begin
			for (int i = 0; i < NUM_STICKS; i++) begin
				result.stick[i] = 14'd0;
			end
			for (int i = 0; i < NUM_SWITCHES; i++) begin
				result.sw[i] = sw_down;
			end
		end
	end

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the ibus frame decoder: frame stimulus, record prediction, result check
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ibfd_pkg::*;

	localparam int BUF_LEN = 36;
	// generous bound on the whole run, far above the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	// cycles to let pass once nothing is outstanding (decode plus output register)
	localparam int SETTLE_CYCLES = 8;

	typedef enum {
		FRM_GOOD,
		FRM_BAD_HDR,
		FRM_BAD_SUM,
		FRM_SHORT,
		FRM_LONG,
		FRM_NOISE
	} frm_kind_t;

	// one output beat as the block should present it
	typedef struct packed {
		logic [13:0] stick_0;
		logic [13:0] stick_1;
		logic [12:0] stick_2;
		logic [13:0] stick_3;
		logic [11:0] switch_0;
		logic [11:0] switch_1;
		logic [11:0] switch_2;
		logic [11:0] switch_3;
		logic [11:0] knob_0;
		logic [11:0] knob_1;
		logic        frame_accepted;
		logic        data_error;
	} dec_rec_t;

	// dut signals
	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  action;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [13:0]           stick_0;
	logic [13:0]           stick_1;
	logic [12:0]           stick_2;
	logic [13:0]           stick_3;
	logic [11:0]           switch_0;
	logic [11:0]           switch_1;
	logic [11:0]           switch_2;
	logic [11:0]           switch_3;
	logic [11:0]           knob_0;
	logic [11:0]           knob_1;
	logic                  frame_accepted;
	logic                  data_error;

	// predictor state: register shadow, byte collection and the held record
	cfg_t        shadow_cfg = CFG_RESET;
	int          byte_cnt = 0;
	logic [15:0] run_sum = '0;
	logic [7:0]  fstore [FRAME_LEN];
	int          held_stk [NUM_STICKS];
	logic [11:0] held_sw [NUM_SWITCHES];
	logic [11:0] held_knob [NUM_KNOBS];

	// records still owed by the block, oldest first
	dec_rec_t    pending_records [$];

	// channel values of the next frame to build
	logic [11:0] chan_plan [10];

	int mismatches = 0;
	int records_seen = 0;
	int beats_sent = 0;
	int cyc = 0;
	int hold_req = 0;
	bit idling_on = 1'b1;

	ibus_frame_decoder_unit #(
		.BUF_LEN(BUF_LEN)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.stick_0       (stick_0),
		.stick_1       (stick_1),
		.stick_2       (stick_2),
		.stick_3       (stick_3),
		.switch_0      (switch_0),
		.switch_1      (switch_1),
		.switch_2      (switch_2),
		.switch_3      (switch_3),
		.knob_0        (knob_0),
		.knob_1        (knob_1),
		.frame_accepted(frame_accepted),
		.data_error    (data_error)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// record prediction
	// ---------------------------------------------------------------

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	// zero a stick whose magnitude is under the deadband
	function automatic int trim_db(int v, logic [7:0] db);
		return (magnitude(v) < int'(db)) ? 0 : v;
	endfunction

	// 12-bit channel k: low byte, then low nibble of the next byte
	function automatic logic [11:0] chan_of(int k);
		return {fstore[2*k+3][3:0], fstore[2*k+2]};
	endfunction

	// pulse width to switch code, unmatched widths pass through
	function automatic logic [11:0] code_switch(logic [11:0] w, bit three_way);
		if (w == W_LOW) begin
			return shadow_cfg.sw_up;
		end
		if (w == W_HIGH) begin
			return shadow_cfg.sw_down;
		end
		if (three_way && (w == W_MID)) begin
			return shadow_cfg.sw_mid;
		end
		return w;
	endfunction

	// byte beat: store and sum while there is room, count saturates
	function automatic void absorb_byte(logic [7:0] b);
		if (byte_cnt < BUF_LEN) begin
			if (byte_cnt < FRAME_LEN) begin
				fstore[byte_cnt] = b;
			end
			if (byte_cnt < SUM_BYTES) begin
				run_sum = run_sum + 16'(b);
			end
			byte_cnt++;
		end
	endfunction

	// idle beat: validate, unpack, range check, queue the record
	function automatic void predict_record();
		logic [15:0] inv;
		logic        ok;
		logic        bad;
		dec_rec_t    r;
		inv = ~run_sum;
		ok = (byte_cnt == FRAME_LEN) && (fstore[0] == HDR0) && (fstore[1] == HDR1)
			&& (fstore[30] == inv[7:0]) && (fstore[31] == inv[15:8]);
		if (ok) begin
			held_stk[0] = trim_db(2 * (int'(chan_of(0)) - int'(W_MID)), shadow_cfg.db_fine);
			held_stk[1] = trim_db(2 * (int'(chan_of(1)) - int'(W_MID)), shadow_cfg.db_fine);
			held_stk[2] = trim_db(int'(chan_of(2)) - int'(W_LOW), shadow_cfg.db_coarse);
			held_stk[3] = trim_db(2 * (int'(chan_of(3)) - int'(W_MID)), shadow_cfg.db_coarse);
			held_sw[0] = code_switch(chan_of(4), 1'b0);
			held_sw[1] = code_switch(chan_of(5), 1'b1);
			held_sw[2] = code_switch(chan_of(6), 1'b1);
			held_sw[3] = code_switch(chan_of(7), 1'b0);
			held_knob[0] = chan_of(8);
			held_knob[1] = chan_of(9);
		end
		// the check runs on every idle, accepted frame or not
		bad = 1'b0;
		for (int k = 0; k < NUM_STICKS; k++) begin
			if (magnitude(held_stk[k]) > int'(shadow_cfg.error_limit)) begin
				bad = 1'b1;
			end
		end
		if ((held_sw[0] == '0) || (held_sw[1] == '0)) begin
			bad = 1'b1;
		end
		if (bad) begin
			for (int k = 0; k < NUM_STICKS; k++) begin
				held_stk[k] = 0;
				held_sw[k] = shadow_cfg.sw_down;
			end
		end
		byte_cnt = 0;
		run_sum = '0;
		r.stick_0 = 14'(held_stk[0]);
		r.stick_1 = 14'(held_stk[1]);
		r.stick_2 = 13'(held_stk[2]);
		r.stick_3 = 14'(held_stk[3]);
		r.switch_0 = held_sw[0];
		r.switch_1 = held_sw[1];
		r.switch_2 = held_sw[2];
		r.switch_3 = held_sw[3];
		r.knob_0 = held_knob[0];
		r.knob_1 = held_knob[1];
		r.frame_accepted = ok;
		r.data_error = bad;
		pending_records.push_back(r);
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// offer one input beat, hold it until accepted, then predict
	task automatic push_beat(logic act, logic [7:0] b);
		@(negedge clk);
		if (idling_on && ($urandom_range(0, 9) == 0)) begin
			// random sender gap
			in_valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		rx_byte = b;
		do begin
			@(posedge clk);
		end while (!in_ready);
		beats_sent++;
		if (act) begin
			predict_record();
		end else begin
			absorb_byte(b);
		end
	endtask

	// drop valid and wait until the block has nothing left to deliver
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_records.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_ERROR_LIMIT:     shadow_cfg.error_limit = val;
			CFG_DEADBAND_FINE:   shadow_cfg.db_fine = val[7:0];
			CFG_DEADBAND_COARSE: shadow_cfg.db_coarse = val[7:0];
			CFG_SWITCH_UP:       shadow_cfg.sw_up = val;
			CFG_SWITCH_DOWN:     shadow_cfg.sw_down = val;
			CFG_SWITCH_MID:      shadow_cfg.sw_mid = val;
			default: ;
		endcase
	endtask

	// all six registers; the 8-bit ones get junk in the unused upper bits
	task automatic apply_cfg(cfg_t c);
		write_reg(CFG_ERROR_LIMIT, c.error_limit);
		write_reg(CFG_DEADBAND_FINE, {4'($urandom_range(0, 15)), c.db_fine});
		write_reg(CFG_DEADBAND_COARSE, {4'($urandom_range(0, 15)), c.db_coarse});
		write_reg(CFG_SWITCH_UP, c.sw_up);
		write_reg(CFG_SWITCH_DOWN, c.sw_down);
		write_reg(CFG_SWITCH_MID, c.sw_mid);
	endtask

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.error_limit = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
			: 12'($urandom_range(1000, 3000));
		c.db_fine = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 40));
		c.db_coarse = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 80));
		c.sw_up = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
		c.sw_down = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
		c.sw_mid = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
		return c;
	endfunction

	// stick widths: mostly near the centers so deadband edges get hit
	function automatic logic [11:0] pick_stick();
		int r;
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4, 5, 6, 7: r = 1470 + $urandom_range(0, 60);
			8, 9, 10:               r = 970 + $urandom_range(0, 60);
			11, 12, 13:             r = $urandom_range(1100, 1900);
			14:                     r = $urandom_range(0, 4095);
			default:                r = ($urandom_range(0, 1) == 0) ? 0 : 4095;
		endcase
		return 12'(r);
	endfunction

	function automatic logic [11:0] pick_switch();
		case ($urandom_range(0, 15))
			0, 1, 2, 3: return W_LOW;
			4, 5, 6:    return W_MID;
			7, 8, 9, 10, 11: return W_HIGH;
			15:         return 12'd0;
			default:    return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic set_plan(int s0, int s1, int s2, int s3, int w0, int w1, int w2, int w3,
		int k0, int k1);
		chan_plan[0] = 12'(s0);
		chan_plan[1] = 12'(s1);
		chan_plan[2] = 12'(s2);
		chan_plan[3] = 12'(s3);
		chan_plan[4] = 12'(w0);
		chan_plan[5] = 12'(w1);
		chan_plan[6] = 12'(w2);
		chan_plan[7] = 12'(w3);
		chan_plan[8] = 12'(k0);
		chan_plan[9] = 12'(k1);
	endtask

	task automatic fill_random_plan();
		for (int k = 0; k < 10; k++) begin
			if (k < 4) begin
				chan_plan[k] = pick_stick();
			end else if (k < 8) begin
				chan_plan[k] = pick_switch();
			end else begin
				chan_plan[k] = 12'($urandom_range(0, 4095));
			end
		end
	endtask

	// build a frame from chan_plan, damage it as asked, send it and the idle beat
	task automatic send_frame(frm_kind_t kind);
		logic [7:0]  fb [40];
		logic [11:0] raw;
		logic [15:0] sum;
		int          n;
		fb[0] = HDR0;
		fb[1] = HDR1;
		// ten planned channels plus four spare ones, upper nibbles are don't-care
		for (int k = 0; k < 14; k++) begin
			raw = (k < 10) ? chan_plan[k] : 12'($urandom_range(0, 4095));
			fb[2*k+2] = raw[7:0];
			fb[2*k+3] = {4'($urandom_range(0, 15)), raw[11:8]};
		end
		sum = '0;
		for (int k = 0; k < SUM_BYTES; k++) begin
			sum = sum + 16'(fb[k]);
		end
		sum = ~sum;
		fb[30] = sum[7:0];
		fb[31] = sum[15:8];
		for (int k = FRAME_LEN; k < 40; k++) begin
			fb[k] = 8'($urandom_range(0, 255));
		end
		n = FRAME_LEN;
		case (kind)
			FRM_BAD_HDR: fb[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
			FRM_BAD_SUM: fb[30 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
			FRM_SHORT:   n = $urandom_range(0, FRAME_LEN - 1);
			// past BUF_LEN the count saturates and bytes are dropped
			FRM_LONG:    n = $urandom_range(FRAME_LEN + 1, 40);
			FRM_NOISE: begin
				n = $urandom_range(0, 40);
				for (int k = 0; k < 40; k++) begin
					fb[k] = 8'($urandom_range(0, 255));
				end
			end
			default: ;
		endcase
		for (int k = 0; k < n; k++) begin
			push_beat(1'b0, fb[k]);
		end
		push_beat(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	task automatic test_directed();
		// idle before any frame: zero record, zero switches trip the check
		push_beat(1'b1, 8'h00);
		// all centered, every switch code, knob extremes
		set_plan(1500, 1500, 1000, 1500, 1000, 1500, 2000, 2000, 0, 4095);
		send_frame(FRM_GOOD);
		// deadband edges on both sides of the threshold
		set_plan(1505, 1504, 1049, 1525, 2000, 1000, 1500, 1000, 4095, 0);
		send_frame(FRM_GOOD);
		set_plan(1495, 1496, 1050, 1524, 1000, 2000, 1000, 2000, 1234, 2345);
		send_frame(FRM_GOOD);
		// error limit exactly met, then just exceeded
		set_plan(2400, 600, 2800, 2400, 1000, 1000, 1000, 1000, 7, 8);
		send_frame(FRM_GOOD);
		set_plan(2401, 1500, 1000, 1500, 1000, 1000, 1000, 1000, 9, 10);
		send_frame(FRM_GOOD);
		set_plan(1500, 1500, 2801, 1500, 1000, 1000, 1000, 1000, 11, 12);
		send_frame(FRM_GOOD);
		// raw extremes on every stick
		set_plan(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
		send_frame(FRM_GOOD);
		set_plan(0, 0, 0, 0, 1000, 1500, 2000, 1000, 0, 0);
		send_frame(FRM_GOOD);
		// unmatched widths, mid width on the two-way switches, zero switches
		set_plan(1500, 1500, 1000, 1500, 1500, 1499, 1501, 1500, 100, 200);
		send_frame(FRM_GOOD);
		set_plan(1500, 1500, 1000, 1500, 0, 1000, 0, 0, 300, 400);
		send_frame(FRM_GOOD);
		set_plan(1500, 1500, 1000, 1500, 1000, 0, 1500, 2000, 500, 600);
		send_frame(FRM_GOOD);
		// rejected frames keep the held record
		set_plan(1700, 1300, 1200, 1600, 2000, 1500, 1000, 1000, 1, 2);
		send_frame(FRM_GOOD);
		send_frame(FRM_BAD_HDR);
		send_frame(FRM_BAD_SUM);
		send_frame(FRM_SHORT);
		send_frame(FRM_LONG);
		send_frame(FRM_NOISE);
		// back-to-back idles
		push_beat(1'b1, 8'hff);
		push_beat(1'b1, 8'h00);
	endtask

	task automatic test_config_sweep();
		cfg_t lo_cfg;
		cfg_t hi_cfg;
		lo_cfg = '0;
		hi_cfg = '1;
		for (int s = 0; s < 4; s++) begin
			settle();
			case (s)
				0: apply_cfg(lo_cfg);
				1: apply_cfg(hi_cfg);
				2: apply_cfg(rand_cfg());
				default: apply_cfg(CFG_RESET);
			endcase
			if (s == 2) begin
				// indexes past the register list must be ignored
				for (int i = int'(CFG_SWITCH_MID) + 1; i < (1 << CFG_IDX_W); i++) begin
					write_reg(CFG_IDX_W'(i), 12'($urandom_range(0, 4095)));
				end
			end
			for (int i = 0; i < 2; i++) begin
				fill_random_plan();
				send_frame(FRM_GOOD);
			end
			send_frame(FRM_BAD_SUM);
		end
	endtask

	// receiver holds off for a long stretch while frames and idles keep coming
	task automatic test_backpressure();
		settle();
		idling_on = 1'b0;
		hold_req = 200;
		for (int i = 0; i < 3; i++) begin
			fill_random_plan();
			send_frame(FRM_GOOD);
		end
		for (int i = 0; i < 12; i++) begin
			push_beat(1'b1, 8'($urandom_range(0, 255)));
		end
		idling_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int r;
		for (int phase = 0; phase < 5; phase++) begin
			settle();
			apply_cfg(rand_cfg());
			stop_at = beats_sent + 130;
			while (beats_sent < stop_at) begin
				fill_random_plan();
				r = $urandom_range(0, 99);
				if (r < 60) begin
					send_frame(FRM_GOOD);
				end else if (r < 68) begin
					send_frame(FRM_BAD_HDR);
				end else if (r < 78) begin
					send_frame(FRM_BAD_SUM);
				end else if (r < 86) begin
					send_frame(FRM_SHORT);
				end else if (r < 94) begin
					send_frame(FRM_LONG);
				end else begin
					send_frame(FRM_NOISE);
				end
			end
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_quiet_tail();
		settle();
		idling_on = 1'b0;
		for (int i = 0; i < 6; i++) begin
			fill_random_plan();
			send_frame(($urandom_range(0, 3) == 0) ? FRM_BAD_SUM : FRM_GOOD);
		end
	endtask

	// ---------------------------------------------------------------
	// receiver: random stall bursts plus the long hold-off on request
	// ---------------------------------------------------------------
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (idling_on && ($urandom_range(0, 7) == 0)) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// result check: each output beat against the oldest expected record
	// ---------------------------------------------------------------
	task automatic match_field(string fname, logic [13:0] want, logic [13:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch on %s in record %0d: expected %0h, got %0h",
					fname, records_seen, want, got);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		dec_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result beat with no record expected at cycle %0d", cyc);
				end
			end else begin
				want = pending_records.pop_front();
				match_field("stick_0", want.stick_0, stick_0);
				match_field("stick_1", want.stick_1, stick_1);
				match_field("stick_2", want.stick_2, stick_2);
				match_field("stick_3", want.stick_3, stick_3);
				match_field("switch_0", want.switch_0, switch_0);
				match_field("switch_1", want.switch_1, switch_1);
				match_field("switch_2", want.switch_2, switch_2);
				match_field("switch_3", want.switch_3, switch_3);
				match_field("knob_0", want.knob_0, knob_0);
				match_field("knob_1", want.knob_1, knob_1);
				match_field("frame_accepted", want.frame_accepted, frame_accepted);
				match_field("data_error", want.data_error, data_error);
			end
			records_seen++;
		end
	end

	// watchdog
	initial begin : watchdog
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ERROR_LIMIT;
		cfg_data = '0;
		in_valid = 1'b0;
		action = 1'b0;
		rx_byte = '0;
		for (int k = 0; k < FRAME_LEN; k++) begin
			fstore[k] = '0;
		end
		for (int k = 0; k < NUM_STICKS; k++) begin
			held_stk[k] = 0;
			held_sw[k] = '0;
		end
		held_knob[0] = '0;
		held_knob[1] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random_traffic();
		test_quiet_tail();
		settle();

		if ((mismatches == 0) && (pending_records.size() == 0)) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
